@@ rtl/dead_reckoning_position_update_defines.svh @@
// assertion macros shared by the dead-reckoning rtl
// the macros expect clk and arst_n in the scope where they are used
`ifndef DEAD_RECKONING_POSITION_UPDATE_DEFINES_SVH
`define DEAD_RECKONING_POSITION_UPDATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DRPU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drpu: same-cycle check failed");

// next-cycle implication, checked out of reset
`define DRPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drpu: next-cycle check failed");

`endif

@@ rtl/drpu_pkg.sv @@
// types, constants and the arctangent table of the dead-reckoning block
// no dependencies; used by every module of the block
package drpu_pkg;

	// sequencer states of the top level
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_T,
		ST_E_LOAD,
		ST_MUL_ELO,
		ST_MUL_EHI,
		ST_NUM_ADD,
		ST_DIV,
		ST_WAIT_COR,
		ST_MUL_XLO,
		ST_MUL_XHI,
		ST_MUL_YLO,
		ST_MUL_YHI,
		ST_Y_ACC,
		ST_Y_SUM,
		ST_DONE
	} fsm_state_t;

	// drive action code that moves the robot
	localparam logic [1:0] ACT_FWD = 2'd0;

	// register map
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_TICK_PERIOD = 2'd0;
	localparam logic [31:0] TICK_PERIOD_RST = 32'd4295;

	// heading in 1/128 degree
	localparam logic [16:0] DEG90  = 17'd11520;
	localparam logic [16:0] DEG180 = 17'd23040;
	localparam logic [16:0] DEG270 = 17'd34560;
	localparam logic [16:0] DEG360 = 17'd46080;
	// 1/128 degree to Q8.24 degree
	localparam int ANG_SHIFT = 17;

	// cordic datapath
	localparam int CORDIC_W = 34;
	localparam int TRIG_W = 33;
	localparam int STEP_W = 5;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

	// shared multiplier
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;

	// scaling of Q2.30 trig values with round half up
	localparam int TRIG_SHIFT = 30;
	localparam logic [29:0] ROUND_Q30 = 30'h2000_0000;

	// radix-256 long division by 255
	localparam logic [8:0] DIGIT_DIVISOR = 9'd255;

	// cordic control from the sequencer
	typedef struct packed {
		logic start;
		logic neg;
		logic signed [CORDIC_W-1:0] z0;
	} cordic_cmd_t;

	// atan(2^-i) in Q8.24 degrees
	function automatic logic [29:0] atan_lut(input logic [STEP_W-1:0] idx);
		logic [29:0] val;
		case (idx)
			5'd0:  val = 30'd754974720;
			5'd1:  val = 30'd445687602;
			5'd2:  val = 30'd235489088;
			5'd3:  val = 30'd119537938;
			5'd4:  val = 30'd60000934;
			5'd5:  val = 30'd30029717;
			5'd6:  val = 30'd15018523;
			5'd7:  val = 30'd7509720;
			5'd8:  val = 30'd3754917;
			5'd9:  val = 30'd1877466;
			5'd10: val = 30'd938734;
			5'd11: val = 30'd469367;
			5'd12: val = 30'd234684;
			5'd13: val = 30'd117342;
			5'd14: val = 30'd58671;
			5'd15: val = 30'd29336;
			5'd16: val = 30'd14668;
			5'd17: val = 30'd7334;
			5'd18: val = 30'd3667;
			5'd19: val = 30'd1833;
			5'd20: val = 30'd917;
			5'd21: val = 30'd458;
			5'd22: val = 30'd229;
			5'd23: val = 30'd115;
			5'd24: val = 30'd57;
			5'd25: val = 30'd29;
			5'd26: val = 30'd14;
			5'd27: val = 30'd7;
			5'd28: val = 30'd4;
			5'd29: val = 30'd2;
			5'd30: val = 30'd1;
			default: val = 30'd0;
		endcase
		return val;
	endfunction

endpackage

@@ rtl/drpu_mul.sv @@
// shared 33x33 signed multiplier with a registered product
// depends on drpu_pkg for the operand and product widths
module drpu_mul import drpu_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// one product per cycle, registered product
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

@@ rtl/drpu_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on drpu_pkg and the assertion macro header
`include "dead_reckoning_position_update_defines.svh"

module drpu_cordic import drpu_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cordic_cmd_t              cmd,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val,
	output logic                     done
);

	logic signed [CORDIC_W-1:0] cx_q, cy_q, z_q;
	logic signed [CORDIC_W-1:0] sx, sy, cx_nx, cy_nx, z_nx, atan_val;
	logic [STEP_W-1:0] step_q;
	logic running_q, done_q, neg_q;
	logic last_step;

	assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// one micro-rotation
	always_comb begin
		sx = cx_q >>> step_q;
		sy = cy_q >>> step_q;
		atan_val = CORDIC_W'(atan_lut(step_q));
		if (!z_q[CORDIC_W-1]) begin
			cx_nx = cx_q - sy;
			cy_nx = cy_q + sx;
			z_nx = z_q - atan_val;
		end else begin
			cx_nx = cx_q + sy;
			cy_nx = cy_q - sx;
			z_nx = z_q + atan_val;
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.start) begin
			running_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (running_q) begin
			step_q <= step_q + 1'b1;
			if (last_step) begin
				running_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// vector and angle, result negated on the last step for the folded half-plane
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cx_q <= CORDIC_K;
			cy_q <= '0;
			z_q <= cmd.z0;
			neg_q <= cmd.neg;
		end else if (running_q) begin
			z_q <= z_nx;
			if (last_step && neg_q) begin
				cx_q <= -cx_nx;
				cy_q <= -cy_nx;
			end else begin
				cx_q <= cx_nx;
				cy_q <= cy_nx;
			end
		end
	end

	assign cos_val = cx_q[TRIG_W-1:0];
	assign sin_val = cy_q[TRIG_W-1:0];
	assign done = done_q;

	`DRPU_ASSERT_IMP(a_done_not_running, done_q, !running_q)
	`DRPU_ASSERT_NEXT(a_start_restarts, cmd.start, running_q && !done_q && step_q == '0)
	`DRPU_ASSERT_NEXT(a_last_sets_done, running_q && last_step && !cmd.start, done_q)

endmodule

@@ rtl/dead_reckoning_position_update.sv @@
// channel  | handshake                 | payload
// input    | in_valid / in_stall       | action intensity heading now_ticks x_in y_in
// output   | out_valid / out_stall     | x_out y_out moved
// config   | psel penable pwrite pready| paddr pwdata prdata (tick_period at 0x0)
//
// forward item: the cordic loop runs beside the divide-by-255 digit loop and the
// seven products through the shared multiplier.
// turn or stop item: the position passes through. in_stall is high while an item is in work.
// the output register holds a result under out_stall while the next item runs.
// reset clears the tick stamp and loads the 1 MHz tick period.
// depends on drpu_pkg, drpu_mul, drpu_cordic and the assertion macro header
`include "dead_reckoning_position_update_defines.svh"

module dead_reckoning_position_update import drpu_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [7:0]          intensity,
	input  logic [15:0]         heading,
	input  logic [31:0]         now_ticks,
	input  logic signed [31:0]  x_in,
	input  logic signed [31:0]  y_in,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  x_out,
	output logic signed [31:0]  y_out,
	output logic                moved
);

	localparam int DIST_W = 32 + POS_FRAC_BITS;
	localparam int E_LSB = 32 - POS_FRAC_BITS;
	localparam int NUM_W = DIST_W + 9;
	localparam int NUM_DIGITS = (NUM_W + 7) / 8;
	localparam int NUM_PAD = NUM_DIGITS * 8;
	localparam int DIG_W = $clog2(NUM_DIGITS);
	localparam int ACC_W = DIST_W + 34;
	localparam int SUM_W = ACC_W - TRIG_SHIFT + 1;

	fsm_state_t state_q, state_d;

	logic in_accept, out_free, cfg_wr;
	logic [31:0] tick_period_q, last_tick_q, ticks_q;
	logic [7:0] intensity_q;
	logic signed [31:0] x_q, y_q, nx_q, ny_q;
	logic [NUM_PAD-1:0] num_q;
	logic [7:0] rem_q;
	logic [DIG_W-1:0] cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic out_valid_q, moved_q;
	logic signed [31:0] x_out_q, y_out_q;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0] p_ext;
	logic [MUL_W-1:0] dist_lo, dist_hi;

	cordic_cmd_t cor_cmd;
	logic signed [TRIG_W-1:0] cos_val, sin_val;
	logic cor_done;

	logic [16:0] hd_sum, hd_wrap;
	logic signed [17:0] hd_fold;
	logic hd_neg;

	logic [15:0] dig_t;
	logic [8:0] dig_r0;
	logic [7:0] q_dig, r_dig;

	logic signed [31:0] sat_in, sat_out;
	logic signed [SUM_W-1:0] sat_sum;
	logic [SUM_W-32:0] sat_top;

	// handshakes
	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign x_out = x_out_q;
	assign y_out = y_out_q;
	assign moved = moved_q;

	// config register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_TICK_PERIOD) ? tick_period_q : 32'd0;

	// heading turned by 90 degrees, folded into [-90, 90]
	always_comb begin
		hd_sum = {1'b0, heading} + DEG90;
		if (hd_sum > DEG360) begin
			hd_wrap = hd_sum - DEG360;
		end else if (hd_sum == DEG360) begin
			hd_wrap = '0;
		end else begin
			hd_wrap = hd_sum;
		end
		hd_neg = 1'b0;
		if (hd_wrap > DEG90 && hd_wrap <= DEG270) begin
			hd_fold = signed'({1'b0, hd_wrap}) - signed'({1'b0, DEG180});
			hd_neg = 1'b1;
		end else if (hd_wrap > DEG270) begin
			hd_fold = signed'({1'b0, hd_wrap}) - signed'({1'b0, DEG360});
		end else begin
			hd_fold = signed'({1'b0, hd_wrap});
		end
	end

	assign cor_cmd.start = in_accept && (action == ACT_FWD);
	assign cor_cmd.neg = hd_neg;
	assign cor_cmd.z0 = CORDIC_W'(hd_fold) <<< ANG_SHIFT;

	drpu_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cor_cmd),
		.cos_val(cos_val),
		.sin_val(sin_val),
		.done(cor_done)
	);

	drpu_mul u_mul (
		.clk(clk),
		.op_a(mul_a),
		.op_b(mul_b),
		.prod(mul_p)
	);

	assign p_ext = ACC_W'(mul_p);
	assign dist_lo = {1'b0, num_q[31:0]};
	assign dist_hi = MUL_W'(num_q[DIST_W-1:32]);

	// one base-256 digit of the divide by 255, a single correction step
	always_comb begin
		dig_t = {rem_q, num_q[NUM_PAD-1 -: 8]};
		dig_r0 = {1'b0, dig_t[7:0]} + {1'b0, dig_t[15:8]};
		if (dig_r0 >= DIGIT_DIVISOR) begin
			q_dig = dig_t[15:8] + 8'd1;
			r_dig = 8'(dig_r0 - DIGIT_DIVISOR);
		end else begin
			q_dig = dig_t[15:8];
			r_dig = dig_r0[7:0];
		end
	end

	// position plus rounded scaled step, saturated to 32 bits
	always_comb begin
		sat_in = (state_q == ST_MUL_YHI) ? x_q : y_q;
		sat_sum = SUM_W'(sat_in) + SUM_W'(acc_q >>> TRIG_SHIFT);
		sat_top = sat_sum[SUM_W-1:31];
		if ((&sat_top) || !(|sat_top)) begin
			sat_out = sat_sum[31:0];
		end else if (sat_sum[SUM_W-1]) begin
			sat_out = 32'sh8000_0000;
		end else begin
			sat_out = 32'sh7FFF_FFFF;
		end
	end

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (action == ACT_FWD) ? ST_MUL_T : ST_DONE;
				end
			end
			ST_MUL_T: begin
				mul_a = {1'b0, ticks_q};
				mul_b = {1'b0, tick_period_q};
				state_d = ST_E_LOAD;
			end
			ST_E_LOAD: state_d = ST_MUL_ELO;
			ST_MUL_ELO: begin
				mul_a = dist_lo;
				mul_b = MUL_W'(intensity_q);
				state_d = ST_MUL_EHI;
			end
			ST_MUL_EHI: begin
				mul_a = dist_hi;
				mul_b = MUL_W'(intensity_q);
				state_d = ST_NUM_ADD;
			end
			ST_NUM_ADD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIG_W'(NUM_DIGITS - 1)) begin
					state_d = ST_WAIT_COR;
				end
			end
			ST_WAIT_COR: begin
				if (cor_done) begin
					state_d = ST_MUL_XLO;
				end
			end
			ST_MUL_XLO: begin
				mul_a = dist_lo;
				mul_b = cos_val;
				state_d = ST_MUL_XHI;
			end
			ST_MUL_XHI: begin
				mul_a = dist_hi;
				mul_b = cos_val;
				state_d = ST_MUL_YLO;
			end
			ST_MUL_YLO: begin
				mul_a = dist_lo;
				mul_b = sin_val;
				state_d = ST_MUL_YHI;
			end
			ST_MUL_YHI: begin
				mul_a = dist_hi;
				mul_b = sin_val;
				state_d = ST_Y_ACC;
			end
			ST_Y_ACC: state_d = ST_Y_SUM;
			ST_Y_SUM: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			tick_period_q <= TICK_PERIOD_RST;
			last_tick_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr == ADDR_TICK_PERIOD) begin
				tick_period_q <= pwdata;
			end
			if (in_accept) begin
				last_tick_q <= now_ticks;
			end
			if (state_q == ST_NUM_ADD) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					ticks_q <= now_ticks - last_tick_q;
					intensity_q <= intensity;
					x_q <= x_in;
					y_q <= y_in;
					nx_q <= x_in;
					ny_q <= y_in;
				end
			end
			// elapsed time in position units
			ST_E_LOAD: num_q <= NUM_PAD'(mul_p[63:E_LSB]);
			// time times intensity plus half the divisor
			ST_MUL_EHI: num_q <= NUM_PAD'(p_ext) + NUM_PAD'(127);
			ST_NUM_ADD: begin
				num_q <= num_q + NUM_PAD'(p_ext <<< 32);
				rem_q <= '0;
			end
			// quotient digits shift in as the dividend shifts out
			ST_DIV: begin
				num_q <= {num_q[NUM_PAD-9:0], q_dig};
				rem_q <= r_dig;
			end
			ST_MUL_XHI: acc_q <= p_ext + ACC_W'(ROUND_Q30);
			ST_MUL_YLO: acc_q <= acc_q + (p_ext <<< 32);
			ST_MUL_YHI: begin
				nx_q <= sat_out;
				acc_q <= p_ext + ACC_W'(ROUND_Q30);
			end
			ST_Y_ACC: acc_q <= acc_q + (p_ext <<< 32);
			ST_Y_SUM: ny_q <= sat_out;
			ST_DONE: begin
				if (out_free) begin
					x_out_q <= nx_q;
					y_out_q <= ny_q;
					moved_q <= (nx_q != x_q) || (ny_q != y_q);
				end
			end
			default: ;
		endcase
	end

	`DRPU_ASSERT_NEXT(a_turn_passes, in_accept && action != ACT_FWD, state_q == ST_DONE && nx_q == $past(x_in) && ny_q == $past(y_in))
	`DRPU_ASSERT_NEXT(a_tick_stamp, in_accept, last_tick_q == $past(now_ticks))
	`DRPU_ASSERT_IMP(a_scale_after_cordic, state_q == ST_MUL_XLO, cor_done)

endmodule

@@ dv/tb_dead_reckoning_position_update.sv @@
// self-checking testbench for the dead-reckoning position update block
// depends on drpu_pkg and dead_reckoning_position_update; predicts every result itself
// directed updates from a stimulus list, then random phases over several tick periods
module tb_dead_reckoning_position_update;
	import drpu_pkg::*;

	localparam int CORDIC_ITERS = 16;
	localparam int POS_FRAC = 16;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam int ANG_90 = 11520;
	localparam int ANG_180 = 23040;
	localparam int ANG_270 = 34560;
	localparam int ANG_360 = 46080;
	localparam int ANG_TO_Q24 = 131072;
	localparam logic signed [127:0] ROUND_HALF = 128'sd536870912;
	localparam logic signed [127:0] POS_HI = 128'sd2147483647;
	localparam logic signed [127:0] POS_LO = -128'sd2147483648;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int HOLD_AT_ITEM = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [31:0] PERIOD_RANDOM = 32'd0;

	// atan(2^-i) in Q8.24 degrees
	localparam longint ATAN_Q24 [32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
		117342, 58671, 29336, 14668, 7334, 3667, 1833, 917, 458, 229,
		115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef enum logic [1:0] {
		DRV_FWD   = ACT_FWD,
		DRV_LEFT  = 2'd1,
		DRV_RIGHT = 2'd2,
		DRV_STOP  = 2'd3
	} drive_op_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  intensity;
		logic [15:0] heading;
		logic [31:0] now_ticks;
		logic [31:0] x;
		logic [31:0] y;
	} drive_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        moved;
	} pos_t;

	typedef struct packed {
		drive_t d;
		logic   typed;
		pos_t   want;
	} dir_row_t;

	localparam pos_t NO_WANT = '0;
	localparam int NUM_DIR = 20;

	// directed updates; typed expectations only for pass-through and zero-distance rows
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		// first forward step after reset, measured from tick 0
		'{'{DRV_FWD,   8'd255, 16'd0,     32'd1000000,  32'h0,        32'h0       }, 1'b0, NO_WANT},
		// turns and stop pass the position through
		'{'{DRV_LEFT,  8'd0,   16'd0,     32'd2000000,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
		'{'{DRV_RIGHT, 8'd128, 16'd46079, 32'd2500000,  32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
			'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
		'{'{DRV_STOP,  8'd255, 16'd65535, 32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A988}, 1'b1,
			'{32'h1234_5678, 32'hEDCB_A988, 1'b0}},
		// zero intensity and zero elapsed ticks give no motion
		'{'{DRV_FWD,   8'd0,   16'd12345, 32'h0010_0000, 32'h0000_007B, 32'hFFFF_FE38}, 1'b1,
			'{32'h0000_007B, 32'hFFFF_FE38, 1'b0}},
		'{'{DRV_FWD,   8'd255, 16'd777,   32'h0010_0000, 32'h0001_0000, 32'h0002_0000}, 1'b1,
			'{32'h0001_0000, 32'h0002_0000, 1'b0}},
		// heading wrap and fold corners
		'{'{DRV_FWD,   8'd255, 16'd0,     32'h0020_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd11520, 32'h0030_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd34560, 32'h0040_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd34561, 32'h0050_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd200, 16'd46079, 32'h0060_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd100, 16'd65535, 32'h0070_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd23040, 32'h0080_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd23041, 32'h0090_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd5760,  32'h00A0_0000, 32'h0,        32'h0       }, 1'b0, NO_WANT},
		// tick count wraps: huge elapsed time drives each axis into saturation
		'{'{DRV_FWD,   8'd255, 16'd34560, 32'h0000_0500, 32'h7FF0_0000, 32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd11520, 32'h0000_0400, 32'h8000_1000, 32'h0       }, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd0,     32'h0000_0300, 32'h0,        32'h7FFF_F000}, 1'b0, NO_WANT},
		'{'{DRV_FWD,   8'd255, 16'd23040, 32'h0000_0200, 32'h0,        32'h8000_0100}, 1'b0, NO_WANT},
		'{'{DRV_LEFT,  8'd255, 16'd0,     32'h0,         32'h0,        32'h0       }, 1'b1,
			'{32'h0, 32'h0, 1'b0}}
	};

	localparam logic [31:0] PHASE_PERIOD [8] = '{
		32'hFFFF_FFFF, 32'd1, 32'd4295, PERIOD_RANDOM,
		32'h0001_0000, PERIOD_RANDOM, PERIOD_RANDOM, 32'h7FFF_FFFF
	};
	localparam idle_mode_t PHASE_IDLE [8] = '{
		IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
		IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
	};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [1:0] action;
	logic [7:0] intensity;
	logic [15:0] heading;
	logic [31:0] now_ticks;
	logic signed [31:0] x_in, y_in;
	logic out_valid, out_stall;
	logic signed [31:0] x_out, y_out;
	logic moved;

	// predictor state: stored tick stamp and tick period
	logic [31:0] odo_last_tick = 32'd0;
	logic [31:0] odo_tick_period = 32'd4295;

	// positions still owed by the block, oldest first
	pos_t expected_pos [$];

	logic [31:0] chain_x = 32'd0, chain_y = 32'd0, send_ticks = 32'd0;
	int src_pct = 0, snk_pct = 0;
	int holds_asked = 0, holds_served = 0;
	int n_sent = 0, n_fwd = 0, n_moved = 0, n_checked = 0, n_fail = 0, n_periods = 0;

	dead_reckoning_position_update #(
		.CORDIC_STEPS(CORDIC_ITERS),
		.POS_FRAC_BITS(POS_FRAC)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .intensity(intensity), .heading(heading),
		.now_ticks(now_ticks), .x_in(x_in), .y_in(y_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_out(x_out), .y_out(y_out), .moved(moved)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// limit on the whole run
	initial begin
		#1_000_000;
		$display("tb_dead_reckoning_position_update: FAIL");
		$finish;
	end

	function automatic logic [31:0] clamp32(input logic signed [127:0] v);
		if (v > POS_HI)
			return 32'h7FFF_FFFF;
		if (v < POS_LO)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// one drive update: new position and tick stamp
	function automatic pos_t advance_position(input drive_t u);
		pos_t r;
		logic [31:0] ticks;
		logic [63:0] prod;
		logic [71:0] num;
		logic [63:0] travel;
		int theta, i;
		bit flip;
		longint cx, cy, z, sx, sy;
		logic signed [127:0] dw, tx, ty, px, py;
		r.x = u.x;
		r.y = u.y;
		r.moved = 1'b0;
		if (u.action == DRV_FWD) begin
			// distance in position units from elapsed ticks and intensity
			ticks = u.now_ticks - odo_last_tick;
			prod = 64'(ticks) * 64'(odo_tick_period);
			num = (prod >> (32 - POS_FRAC)) * u.intensity + 127;
			travel = num / 255;
			// turn by 90 degrees, reduce, fold into the right half plane
			theta = int'(u.heading) + ANG_90;
			if (theta > ANG_360)
				theta -= ANG_360;
			theta = theta % ANG_360;
			flip = 1'b0;
			if (theta > ANG_90 && theta <= ANG_270) begin
				theta -= ANG_180;
				flip = 1'b1;
			end else if (theta > ANG_270) begin
				theta -= ANG_360;
			end
			// rotation-mode cordic in Q2.30
			z = longint'(theta) * ANG_TO_Q24;
			cx = CORDIC_GAIN;
			cy = 0;
			for (i = 0; i < CORDIC_ITERS; i++) begin
				sx = cx >>> i;
				sy = cy >>> i;
				if (z >= 0) begin
					cx -= sy;
					cy += sx;
					z -= ATAN_Q24[i];
				end else begin
					cx += sy;
					cy -= sx;
					z += ATAN_Q24[i];
				end
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			// scale by distance with round half up, then saturate
			dw = {64'd0, travel};
			tx = cx;
			ty = cy;
			px = $signed(u.x);
			py = $signed(u.y);
			r.x = clamp32(((dw * tx + ROUND_HALF) >>> 30) + px);
			r.y = clamp32(((dw * ty + ROUND_HALF) >>> 30) + py);
			r.moved = (r.x != u.x) || (r.y != u.y);
		end
		odo_last_tick = u.now_ticks;
		return r;
	endfunction

	// random update: mostly a running track, some noise and corners
	function automatic drive_t random_update();
		drive_t u;
		int roll;
		roll = $urandom_range(99);
		u.action = (roll < 62) ? DRV_FWD : 2'($urandom_range(DRV_STOP, DRV_LEFT));
		roll = $urandom_range(99);
		if (roll < 5)
			u.intensity = 8'd0;
		else if (roll < 12)
			u.intensity = 8'd255;
		else
			u.intensity = 8'($urandom);
		u.heading = ($urandom_range(99) < 8) ? 16'($urandom) : 16'($urandom_range(ANG_360 - 1));
		roll = $urandom_range(99);
		if (roll < 10)
			u.now_ticks = $urandom;
		else if (roll < 16)
			u.now_ticks = send_ticks;
		else
			u.now_ticks = send_ticks + ($urandom >> $urandom_range(31, 8));
		roll = $urandom_range(99);
		if (roll < 55) begin
			u.x = chain_x;
			u.y = chain_y;
		end else if (roll < 88) begin
			u.x = $urandom;
			u.y = $urandom;
		end else begin
			u.x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			u.y = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		return u;
	endfunction

	// offer one transaction, record its expectation on acceptance, then maybe idle
	task automatic offer_update(input drive_t u, input bit typed, input pos_t want);
		pos_t got;
		action <= u.action;
		intensity <= u.intensity;
		heading <= u.heading;
		now_ticks <= u.now_ticks;
		x_in <= u.x;
		y_in <= u.y;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = advance_position(u);
		expected_pos.push_back(typed ? want : got);
		chain_x = got.x;
		chain_y = got.y;
		send_ticks = u.now_ticks;
		n_sent++;
		if (u.action == DRV_FWD)
			n_fwd++;
		if (got.moved)
			n_moved++;
		while ($urandom_range(99) < src_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// config write: setup then access
	task automatic write_tick_period(input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TICK_PERIOD;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		odo_tick_period = val;
		n_periods++;
	endtask

	task automatic wait_for_results();
		while (expected_pos.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stall, plus long holds on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < snk_pct);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin : result_check
		pos_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pos.size() == 0) begin
				$error("unexpected transaction: x_out=%h y_out=%h moved=%b", x_out, y_out, moved);
				n_fail++;
			end else begin
				want = expected_pos.pop_front();
				if (x_out !== want.x) begin
					$error("x_out: expected %h, got %h", want.x, x_out);
					n_fail++;
				end
				if (y_out !== want.y) begin
					$error("y_out: expected %h, got %h", want.y, y_out);
					n_fail++;
				end
				if (moved !== want.moved) begin
					$error("moved: expected %b, got %b", want.moved, moved);
					n_fail++;
				end
				n_checked++;
			end
		end
	end

	// stimulus sequence
	initial begin
		int p, k;
		logic [31:0] period;
		drive_t u;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		action <= DRV_STOP;
		intensity <= '0;
		heading <= '0;
		now_ticks <= '0;
		x_in <= '0;
		y_in <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset tick period, back to back
		for (k = 0; k < NUM_DIR; k++)
			offer_update(DIR_ROWS[k].d, DIR_ROWS[k].typed, DIR_ROWS[k].want);
		in_valid <= 1'b0;
		wait_for_results();

		// random phases, each with its own tick period and idle pattern
		for (p = 0; p < 8; p++) begin
			period = PHASE_PERIOD[p];
			if (period == PERIOD_RANDOM)
				period = ($urandom >> $urandom_range(31)) | 32'd1;
			write_tick_period(period);
			case (PHASE_IDLE[p])
				IDLE_NONE: begin
					src_pct = 0;
					snk_pct = 0;
				end
				IDLE_SENDER: begin
					src_pct = 52;
					snk_pct = 0;
				end
				IDLE_RECEIVER: begin
					src_pct = 0;
					snk_pct = 52;
				end
				default: begin
					src_pct = 9;
					snk_pct = 9;
				end
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// long output hold while the sender keeps offering
				if (k == HOLD_AT_ITEM && PHASE_IDLE[p] == IDLE_NONE)
					holds_asked++;
				u = random_update();
				offer_update(u, 1'b0, NO_WANT);
			end
			in_valid <= 1'b0;
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d of %0d updates: %0d forward, %0d moved, %0d tick period writes",
			n_checked, n_sent, n_fwd, n_moved, n_periods);
		$display("idle patterns none/sender/receiver/both, %0d long output holds", holds_asked);
		if (n_fail == 0)
			$display("tb_dead_reckoning_position_update: PASS");
		else
			$display("tb_dead_reckoning_position_update: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/drpu_pkg.sv
rtl/drpu_mul.sv
rtl/drpu_cordic.sv
rtl/dead_reckoning_position_update.sv
dv/tb_dead_reckoning_position_update.sv
